[hdl/apif_pkg.sv]
// ----------------------------------------------------------------------------
// All-pole IIR filter package
// Shared widths, codes and types for the all-pole IIR filter block.
// ----------------------------------------------------------------------------
`default_nettype none

package apif_pkg;

    localparam int MAX_ORDER        = 16;
    localparam int DATA_W           = 16;
    localparam int COEF_IDX_FIELD_W = 5;
    localparam int CFG_ORDER_W      = 5;
    localparam int PROD_W           = 2 * DATA_W;
    localparam int ORDER_W          = $clog2(MAX_ORDER + 1);
    localparam int COEF_IDX_W       = $clog2(MAX_ORDER + 1);
    localparam int HIST_IDX_W       = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int ACC_W            = PROD_W + $clog2(MAX_ORDER + 1) + 1;
    localparam int QCNT_W           = $clog2(DATA_W);
    localparam int FRAC_SHIFT       = 12;

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_FILTER_ORDER = 1'b0;

    localparam logic CMD_FILTER    = 1'b0;
    localparam logic CMD_LOAD_COEF = 1'b1;

    localparam logic signed [DATA_W-1:0] A0_RESET   = 16'sd4096;
    localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic [DATA_W-1:0]        MAG_POS_MAX = 16'h7FFF;
    localparam logic [DATA_W-1:0]        MAG_NEG_MAX = 16'h8000;

    typedef struct packed {
        logic signed [DATA_W-1:0] filtered;
        logic                     saturated;
        logic                     gain_error;
    } apif_result_t;

    typedef struct packed {
        logic load;
        logic issue;
    } apif_mac_ctl_t;

endpackage

`default_nettype wire

[hdl/apif_channels.sv]
// ----------------------------------------------------------------------------
// All-pole IIR filter channels
// Valid/ready channel interfaces for the input items and the result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface apif_in_if;
    import apif_pkg::*;

    logic                               valid;
    logic                               ready;
    logic                               cmd;
    logic [COEF_IDX_FIELD_W-1:0]        coef_index;
    logic signed [DATA_W-1:0]           value;

    modport source (output valid, output cmd, output coef_index, output value, input ready);
    modport sink   (input valid, input cmd, input coef_index, input value, output ready);
endinterface

interface apif_out_if;
    import apif_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] filtered;
    logic                     saturated;
    logic                     gain_error;

    modport source (output valid, output filtered, output saturated, output gain_error,
                    input ready);
    modport sink   (input valid, input filtered, input saturated, input gain_error,
                    output ready);
endinterface

`default_nettype wire

[hdl/all_pole_iir_filter_unit.sv]
// ----------------------------------------------------------------------------
// All-pole IIR filter unit
// Direct-form all-pole filter with loadable denominator coefficients.
// ----------------------------------------------------------------------------
// The item channel carries two kinds of beats. A coefficient beat (cmd 1)
// writes a[coef_index] in the cycle it is accepted and leaves the unit ready.
// A sample beat (cmd 0) computes y = (x - sum a[k]*y[n-k]) / a[0] and yields
// one result beat on the result channel.
// A sample passes from acceptance to the result register through these
// steps, where order is filter_order capped at 16: one multiply per tap on the
// shared multiplier, a drain state, a start state, the serial divider (check,
// 16 steps, finish, done) and an emit state. With order zero there are no
// multiplies and no drain state. An overflowing or zero-gain sample skips the
// 16 steps. The unit is not ready while a sample is in flight, so it takes no
// new item until that sample has passed through the emit state.
// filter_order is written over the APB port at byte address 0 and is read
// back there; it must be written only while the unit is idle.
// A finished result sits in an output register, so a new item is taken
// while it waits. If the receiver stalls, the next sample holds at its end
// until the output register is free, and the history advances then.
// Reset clears the output history, sets a[0] to 1.0 and the other
// coefficients and filter_order to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module all_pole_iir_filter_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [apif_pkg::PADDR_W-1:0]    paddr,
    input  logic [apif_pkg::PDATA_W-1:0]    pwdata,
    output logic [apif_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    apif_in_if.sink                         item,
    apif_out_if.source                      result
);
    import apif_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_MAC       = 6'b000010,
        S_DRAIN     = 6'b000100,
        S_DIV_START = 6'b001000,
        S_DIV_WAIT  = 6'b010000,
        S_EMIT      = 6'b100000
    } apif_state_t;

    apif_state_t              state_reg, state_next;
    logic [CFG_ORDER_W-1:0]   filter_order_reg;
    logic signed [DATA_W-1:0] coef_reg [0:MAX_ORDER];
    logic signed [DATA_W-1:0] hist_reg [0:MAX_ORDER-1];
    logic [ORDER_W-1:0]       order_reg;
    logic [HIST_IDX_W-1:0]    tap_reg;
    logic                     out_full_reg;
    apif_result_t             out_data_reg;

    logic                     item_fire;
    logic                     sample_fire;
    logic                     coef_we;
    logic                     cfg_we;
    logic                     last_tap;
    logic                     emit_ok;
    logic [ORDER_W-1:0]       order_eff;
    logic signed [ACC_W-1:0]  acc_init;
    logic signed [ACC_W-1:0]  acc;
    logic signed [DATA_W-1:0] mac_coef;
    logic signed [DATA_W-1:0] mac_hist;
    apif_mac_ctl_t            mac_ctl;
    logic                     div_done;
    apif_result_t             div_res;

    assign item.ready  = (state_reg == S_IDLE);
    assign item_fire   = item.valid && item.ready;
    assign sample_fire = item_fire && (item.cmd == CMD_FILTER);
    assign coef_we     = item_fire && (item.cmd == CMD_LOAD_COEF)
                         && (32'(item.coef_index) <= MAX_ORDER);

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite
                    && (paddr[PADDR_W-1:2] == REG_FILTER_ORDER);
    assign prdata = (paddr[PADDR_W-1:2] == REG_FILTER_ORDER)
                    ? PDATA_W'(filter_order_reg) : '0;

    always_comb
    begin
        if (32'(filter_order_reg) > MAX_ORDER)
        begin
            order_eff = ORDER_W'(MAX_ORDER);
        end
        else
        begin
            order_eff = ORDER_W'(filter_order_reg);
        end
    end

    assign acc_init = {{(ACC_W - DATA_W){item.value[DATA_W-1]}}, item.value} << FRAC_SHIFT;
    assign last_tap = (ORDER_W'(tap_reg) + ORDER_W'(1)) == order_reg;
    assign emit_ok  = (state_reg == S_EMIT) && (!out_full_reg || result.ready);
    assign mac_coef = coef_reg[COEF_IDX_W'(tap_reg) + COEF_IDX_W'(1)];
    assign mac_hist = hist_reg[tap_reg];

    assign mac_ctl.load  = sample_fire;
    assign mac_ctl.issue = (state_reg == S_MAC);

    apif_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mac_ctl),
        .load_value (acc_init),
        .coef       (mac_coef),
        .hist       (mac_hist),
        .acc        (acc)
    );

    apif_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DIV_START),
        .dividend (acc),
        .divisor  (coef_reg[0]),
        .done     (div_done),
        .res      (div_res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_fire)
                begin
                    state_next = (order_eff == '0) ? S_DIV_START : S_MAC;
                end
            end
            S_MAC:
            begin
                if (last_tap)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            filter_order_reg <= '0;
            out_full_reg     <= 1'b0;
            for (int i = 0; i <= MAX_ORDER; i++)
            begin
                coef_reg[i] <= '0;
            end
            coef_reg[0] <= A0_RESET;
            for (int i = 0; i < MAX_ORDER; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                filter_order_reg <= pwdata[CFG_ORDER_W-1:0];
            end
            if (coef_we)
            begin
                coef_reg[COEF_IDX_W'(item.coef_index)] <= item.value;
            end
            if (emit_ok)
            begin
                out_full_reg <= 1'b1;
                for (int i = MAX_ORDER - 1; i > 0; i--)
                begin
                    hist_reg[i] <= hist_reg[i-1];
                end
                hist_reg[0] <= div_res.filtered;
            end
            else if (result.ready)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            order_reg <= order_eff;
            tap_reg   <= '0;
        end
        else if (state_reg == S_MAC)
        begin
            tap_reg <= tap_reg + HIST_IDX_W'(1);
        end
        if (emit_ok)
        begin
            out_data_reg <= div_res;
        end
    end

    assign result.valid      = out_full_reg;
    assign result.filtered   = out_data_reg.filtered;
    assign result.saturated  = out_data_reg.saturated;
    assign result.gain_error = out_data_reg.gain_error;

endmodule

`default_nettype wire

[hdl/apif_mac.sv]
// ----------------------------------------------------------------------------
// All-pole IIR filter multiply-accumulate unit
// One shared signed multiplier with a registered product feeding a
// subtracting accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module apif_mac (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  apif_pkg::apif_mac_ctl_t                ctl,
    input  logic signed [apif_pkg::ACC_W-1:0]      load_value,
    input  logic signed [apif_pkg::DATA_W-1:0]     coef,
    input  logic signed [apif_pkg::DATA_W-1:0]     hist,
    output logic signed [apif_pkg::ACC_W-1:0]      acc
);
    import apif_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctl.issue && !ctl.load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            prod_reg <= coef * hist;
        end
        if (ctl.load)
        begin
            acc_reg <= load_value;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg - {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

[hdl/apif_div.sv]
// ----------------------------------------------------------------------------
// All-pole IIR filter serial divider
// Signed division truncated toward zero, one quotient bit per cycle, with
// early overflow detection, saturation to 16 bits and a zero-divisor flag.
// ----------------------------------------------------------------------------
`default_nettype none

module apif_div (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [apif_pkg::ACC_W-1:0]      dividend,
    input  logic signed [apif_pkg::DATA_W-1:0]     divisor,
    output logic                                   done,
    output apif_pkg::apif_result_t                 res
);
    import apif_pkg::*;

    typedef enum logic [3:0] {
        D_IDLE  = 4'b0001,
        D_CHECK = 4'b0010,
        D_STEP  = 4'b0100,
        D_DONE  = 4'b1000
    } apif_div_state_t;

    apif_div_state_t   state_reg, state_next;
    logic              done_reg;
    logic [ACC_W-1:0]  rem_reg;
    logic [ACC_W-1:0]  dsh_reg;
    logic [DATA_W-1:0] dmag_reg;
    logic [DATA_W-1:0] q_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              neg_reg;
    logic              zero_reg;
    logic              ovf_reg;
    apif_result_t      res_reg;

    logic [ACC_W-1:0]  mag_n;
    logic [DATA_W-1:0] mag_d;
    logic              ovf;
    logic              fit;
    apif_result_t      fin;

    always_comb
    begin
        mag_n = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
        mag_d = divisor[DATA_W-1] ? DATA_W'(-divisor) : DATA_W'(divisor);
        ovf   = rem_reg >= (ACC_W'(dmag_reg) << DATA_W);
        fit   = rem_reg >= dsh_reg;
    end

    always_comb
    begin
        fin.filtered   = '0;
        fin.saturated  = 1'b0;
        fin.gain_error = 1'b0;
        if (zero_reg)
        begin
            fin.gain_error = 1'b1;
        end
        else if (neg_reg)
        begin
            if (ovf_reg || q_reg > MAG_NEG_MAX)
            begin
                fin.filtered  = SAMPLE_MIN;
                fin.saturated = 1'b1;
            end
            else
            begin
                fin.filtered = DATA_W'(-q_reg);
            end
        end
        else
        begin
            if (ovf_reg || q_reg > MAG_POS_MAX)
            begin
                fin.filtered  = SAMPLE_MAX;
                fin.saturated = 1'b1;
            end
            else
            begin
                fin.filtered = q_reg;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    state_next = D_CHECK;
                end
            end
            D_CHECK:
            begin
                if (zero_reg || ovf)
                begin
                    state_next = D_DONE;
                end
                else
                begin
                    state_next = D_STEP;
                end
            end
            D_STEP:
            begin
                if (cnt_reg == QCNT_W'(DATA_W - 1))
                begin
                    state_next = D_DONE;
                end
            end
            D_DONE:
            begin
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == D_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    rem_reg  <= mag_n;
                    dmag_reg <= mag_d;
                    neg_reg  <= dividend[ACC_W-1] ^ divisor[DATA_W-1];
                    zero_reg <= (divisor == '0);
                end
            end
            D_CHECK:
            begin
                ovf_reg <= ovf;
                dsh_reg <= ACC_W'(dmag_reg) << (DATA_W - 1);
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            D_STEP:
            begin
                if (fit)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                q_reg   <= {q_reg[DATA_W-2:0], fit};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            D_DONE:
            begin
                res_reg <= fin;
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

[hdl/apif_checker.sv]
// ----------------------------------------------------------------------------
// All-pole IIR filter port checker
// Concurrent checks on the top-level channels, bound to the filter unit.
// ----------------------------------------------------------------------------
`default_nettype none

module apif_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            in_cmd,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic signed [apif_pkg::DATA_W-1:0] out_filtered,
    input  logic                            out_saturated,
    input  logic                            out_gain_error
);
    import apif_pkg::*;

    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_cmd == CMD_FILTER) |=> !in_ready)
        else $error("unit stayed ready after a sample beat");

    a_coef_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_cmd == CMD_LOAD_COEF) |=> in_ready)
        else $error("unit went busy after a coefficient beat");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_saturated && out_gain_error))
        else $error("saturated and gain_error raised together");

    a_gain_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_gain_error |-> (out_filtered == '0))
        else $error("gain_error beat carries a nonzero sample");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_filtered)
        && $stable(out_saturated) && $stable(out_gain_error))
        else $error("stalled result beat changed");

endmodule

bind all_pole_iir_filter_unit apif_checker u_apif_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (item.valid),
    .in_ready       (item.ready),
    .in_cmd         (item.cmd),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_filtered   (result.filtered),
    .out_saturated  (result.saturated),
    .out_gain_error (result.gain_error)
);

`default_nettype wire
